// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker of the priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Check a property on every rising edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned Capacity  = 16;
  localparam int unsigned CntW      = $clog2(Capacity + 1);
  localparam int unsigned CountOutW = 5;
  localparam int unsigned IdW       = 8;
  localparam int unsigned PrioW     = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_e;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/core/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller plus datapath.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request per transfer:
//   func_i selects insert or remove, entry_id_i names the entry and
//   priority_req_i gives its signed priority on insert.
//   Output channel (out_valid_o/out_ready_i) returns one result per request:
//   status, head entry (highest priority, oldest among equals) and count.
//   The table keeps up to 16 entries sorted in flip-flops; each request passes
//   through a compare step of parallel compares over all slots (S_EVAL) and
//   a parallel shift step (S_UPDATE), registered in turn, before out_valid_o.
//   The controller runs this compare-then-shift sequence for each request;
//   the next request is taken in the update cycle.
//   A finished result waits in the output register; while it is not taken,
//   the following request still gets through its compare cycle, then holds in
//   update and in_ready_o stays low until the receiver drains the result.
//   Reset empties the queue and the output register; no clearing pass.
module sorted_priority_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [spq_pkg::IdW-1:0]           entry_id_i,
  input  logic signed [spq_pkg::PrioW-1:0]  priority_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic                              head_valid_o,
  output logic [spq_pkg::IdW-1:0]           head_id_o,
  output logic signed [spq_pkg::PrioW-1:0]  head_priority_o,
  output logic [spq_pkg::CountOutW-1:0]     entry_count_o
);
  import spq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spq_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .func_i          (func_i),
    .entry_id_i      (entry_id_i),
    .priority_req_i  (priority_req_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .head_valid_o    (head_valid_o),
    .head_id_o       (head_id_o),
    .head_priority_o (head_priority_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

// ===== rtl/core/spq_datapath.sv =====
// Datapath: request capture, sorted slot table, compare flags and result register.
module spq_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spq_pkg::dp_cmd_t                  cmd_i,
  output spq_pkg::dp_status_t               stat_o,
  input  logic                              func_i,
  input  logic [spq_pkg::IdW-1:0]           entry_id_i,
  input  logic signed [spq_pkg::PrioW-1:0]  priority_req_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [1:0]                        status_o,
  output logic                              head_valid_o,
  output logic [spq_pkg::IdW-1:0]           head_id_o,
  output logic signed [spq_pkg::PrioW-1:0]  head_priority_o,
  output logic [spq_pkg::CountOutW-1:0]     entry_count_o
);
  import spq_pkg::*;

  func_e                   req_func_q;
  logic [IdW-1:0]          req_id_q;
  logic signed [PrioW-1:0] req_prio_q;

  logic signed [PrioW-1:0] slot_prio_q [Capacity];
  logic signed [PrioW-1:0] slot_prio_d [Capacity];
  logic [IdW-1:0]          slot_id_q   [Capacity];
  logic [IdW-1:0]          slot_id_d   [Capacity];
  logic [CntW-1:0]         count_q, count_d;

  logic [Capacity-1:0] match, ge, after;
  logic [Capacity-1:0] ge_q, after_q;
  logic                match_any_q, full_q;

  logic    do_ins, do_rm;
  status_e status_d;

  logic                    out_valid_q;
  status_e                 res_status_q;
  logic                    res_head_valid_q;
  logic [IdW-1:0]          res_head_id_q;
  logic signed [PrioW-1:0] res_head_prio_q;
  logic [CntW-1:0]         res_count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_func_q <= func_e'(func_i);
      req_id_q   <= entry_id_i;
      req_prio_q <= priority_req_i;
    end
  end

  // Per-slot compares; only held positions take part.
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      match[i] = (CntW'(i) < count_q) && (slot_id_q[i] == req_id_q);
      ge[i]    = (CntW'(i) < count_q) && (slot_prio_q[i] >= req_prio_q);
    end
    after[0] = match[0];
    for (int i = 1; i < Capacity; i++) begin
      after[i] = after[i-1] | match[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      ge_q        <= ge;
      after_q     <= after;
      match_any_q <= |match;
      full_q      <= (count_q == CntW'(Capacity));
    end
  end

  always_comb begin
    do_ins = 1'b0;
    do_rm  = 1'b0;
    if (req_func_q == FUNC_INSERT) begin
      if (match_any_q)  status_d = ST_DUPLICATE;
      else if (full_q)  status_d = ST_FULL;
      else begin
        status_d = ST_OK;
        do_ins   = 1'b1;
      end
    end else begin
      if (match_any_q) begin
        status_d = ST_OK;
        do_rm    = 1'b1;
      end else begin
        status_d = ST_NOT_FOUND;
      end
    end
  end

  // Shift the table: insert opens a gap after the last entry of equal or
  // higher priority, remove closes the gap at the matching slot.
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      slot_prio_d[i] = slot_prio_q[i];
      slot_id_d[i]   = slot_id_q[i];
    end
    if (do_ins) begin
      if (!ge_q[0]) begin
        slot_prio_d[0] = req_prio_q;
        slot_id_d[0]   = req_id_q;
      end
      for (int i = 1; i < Capacity; i++) begin
        if (!ge_q[i]) begin
          if (ge_q[i-1]) begin
            slot_prio_d[i] = req_prio_q;
            slot_id_d[i]   = req_id_q;
          end else begin
            slot_prio_d[i] = slot_prio_q[i-1];
            slot_id_d[i]   = slot_id_q[i-1];
          end
        end
      end
    end else if (do_rm) begin
      for (int i = 0; i < Capacity - 1; i++) begin
        if (after_q[i]) begin
          slot_prio_d[i] = slot_prio_q[i+1];
          slot_id_d[i]   = slot_id_q[i+1];
        end
      end
    end
    if (do_ins)     count_d = count_q + CntW'(1);
    else if (do_rm) count_d = count_q - CntW'(1);
    else            count_d = count_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      for (int i = 0; i < Capacity; i++) begin
        slot_prio_q[i] <= slot_prio_d[i];
        slot_id_q[i]   <= slot_id_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      res_status_q     <= status_d;
      res_head_valid_q <= (count_d != '0);
      res_head_id_q    <= (count_d != '0) ? slot_id_d[0] : '0;
      res_head_prio_q  <= (count_d != '0) ? slot_prio_d[0] : '0;
      res_count_q      <= count_d;
    end
  end

  assign stat_o.out_busy = out_valid_q;
  assign out_valid_o     = out_valid_q;
  assign status_o        = res_status_q;
  assign head_valid_o    = res_head_valid_q;
  assign head_id_o       = res_head_id_q;
  assign head_priority_o = res_head_prio_q;
  assign entry_count_o   = res_count_q[CountOutW-1:0];

endmodule

// ===== rtl/core/spq_ctrl.sv =====
// Controller: sequences capture, compare and table update for each request.
module spq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  input  spq_pkg::dp_status_t stat_i,
  output spq_pkg::dp_cmd_t    cmd_o
);
  import spq_pkg::*;

  state_e state_q, state_d;
  logic   can_load;
  logic   accept;

  // The result register is free when empty or drained in this cycle.
  assign can_load = !stat_i.out_busy || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (can_load) state_d = accept ? S_EVAL : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
      end
      S_UPDATE: begin
        in_ready_o   = can_load;
        cmd_o.update = can_load;
      end
      default: ;
    endcase
    cmd_o.capture = in_valid_i && in_ready_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/spq_checker.sv =====
// Port-level checker of the sorted priority queue, bound to the top level.
`include "assert_macros.svh"

module spq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              func_i,
  input logic [spq_pkg::IdW-1:0]           entry_id_i,
  input logic signed [spq_pkg::PrioW-1:0]  priority_req_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [1:0]                        status_o,
  input logic                              head_valid_o,
  input logic [spq_pkg::IdW-1:0]           head_id_o,
  input logic signed [spq_pkg::PrioW-1:0]  head_priority_o,
  input logic [spq_pkg::CountOutW-1:0]     entry_count_o
);
  import spq_pkg::*;

  logic unused_in;
  assign unused_in = func_i ^ (^entry_id_i) ^ (^priority_req_i) ^ (^status_o);

  // Hold a stalled result.
  `SPQ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(head_id_o) && $stable(entry_count_o))
  // Head flag follows the count.
  `SPQ_ASSERT(a_head_flag, out_valid_o |-> head_valid_o == (entry_count_o != '0))
  // Empty queue reports a zero head.
  `SPQ_ASSERT(a_empty_zero, out_valid_o && !head_valid_o |-> head_id_o == '0 && head_priority_o == '0)
  // A transfer in is followed by a compare cycle that takes no request.
  `SPQ_ASSERT(a_one_per_two, in_valid_i && in_ready_o |=> !in_ready_o)
  // Reset leaves no result standing.
  `SPQ_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

// ===== test/spq_result_checker.sv =====
// Result checker for the sorted priority queue: tracks the table and compares every result.
module spq_result_checker
  import spq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     func_i,
  input  logic [IdW-1:0]           entry_id_i,
  input  logic signed [PrioW-1:0]  priority_req_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [1:0]               status_i,
  input  logic                     head_valid_i,
  input  logic [IdW-1:0]           head_id_i,
  input  logic signed [PrioW-1:0]  head_priority_i,
  input  logic [CountOutW-1:0]     entry_count_i,
  output int unsigned              errors_o,
  output int unsigned              pending_o
);

  typedef struct packed {
    status_e                 status;
    logic                    head_valid;
    logic [IdW-1:0]          head_id;
    logic signed [PrioW-1:0] head_prio;
    logic [CountOutW-1:0]    count;
  } queue_result_t;

  logic signed [PrioW-1:0] slot_prio_q [Capacity];
  logic [IdW-1:0]          slot_id_q   [Capacity];
  int unsigned             held_q = 0;
  int unsigned             mismatches = 0;
  queue_result_t           expected_results_q [$];

  function automatic int unsigned find_slot(logic [IdW-1:0] id);
    for (int unsigned i = 0; i < held_q; i++) begin
      if (slot_id_q[i] == id) return i;
    end
    return held_q;
  endfunction

  // Apply one request to the tracked table and return the result it should produce.
  function automatic queue_result_t predict_queue_op(func_e op, logic [IdW-1:0] id,
                                                     logic signed [PrioW-1:0] prio);
    queue_result_t res;
    int unsigned   pos;
    pos = find_slot(id);
    res.status = ST_OK;
    if (op == FUNC_INSERT) begin
      if (pos < held_q) begin
        res.status = ST_DUPLICATE;
      end else if (held_q >= Capacity) begin
        res.status = ST_FULL;
      end else begin
        // land behind every entry of equal or higher priority
        pos = 0;
        while (pos < held_q && slot_prio_q[pos] >= prio) pos++;
        for (int unsigned i = held_q; i > pos; i--) begin
          slot_prio_q[i] = slot_prio_q[i-1];
          slot_id_q[i]   = slot_id_q[i-1];
        end
        slot_prio_q[pos] = prio;
        slot_id_q[pos]   = id;
        held_q++;
      end
    end else if (pos >= held_q) begin
      res.status = ST_NOT_FOUND;
    end else begin
      for (int unsigned i = pos; i + 1 < held_q; i++) begin
        slot_prio_q[i] = slot_prio_q[i+1];
        slot_id_q[i]   = slot_id_q[i+1];
      end
      held_q--;
    end
    res.head_valid = (held_q != 0);
    res.head_id    = (held_q != 0) ? slot_id_q[0] : '0;
    res.head_prio  = (held_q != 0) ? slot_prio_q[0] : '0;
    res.count      = held_q[CountOutW-1:0];
    return res;
  endfunction

  task automatic compare_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    queue_result_t want;
    if (!rst_ni) begin
      held_q = 0;
      expected_results_q.delete();
    end else begin
      // retire the result first so a fresh prediction is never matched in the same cycle
      if (out_valid_i && out_ready_i) begin
        if (expected_results_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: status %0d head %0b id %0d prio %0d count %0d",
                   $time, status_i, head_valid_i, head_id_i, head_priority_i,
                   entry_count_i);
        end else begin
          want = expected_results_q.pop_front();
          compare_field("status", want.status, status_i);
          compare_field("head_valid", want.head_valid, head_valid_i);
          compare_field("head_id", want.head_id, head_id_i);
          compare_field("head_priority", want.head_prio, head_priority_i);
          compare_field("entry_count", want.count, entry_count_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results_q.push_back(predict_queue_op(func_e'(func_i), entry_id_i,
                                                      priority_req_i));
      end
    end
    errors_o  <= mismatches;
    pending_o <= expected_results_q.size();
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the sorted priority queue: stimulus, back-pressure and verdict.
module tb;
  import spq_pkg::*;

  localparam int unsigned RandomItems   = 1500;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 80;

  localparam logic signed [PrioW-1:0] PrioMax = 32'sh7fff_ffff;
  localparam logic signed [PrioW-1:0] PrioMin = 32'sh8000_0000;
  localparam logic signed [PrioW-1:0] FillPrio [14] = '{
    -32'sd1, 32'sd0, 32'sd7, 32'sd7, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd3,
    -32'sd5, 32'sd7, 32'sd0, 32'sd100, -32'sd100, 32'sd7, 32'sd1
  };

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  func_e                   func_sel     = FUNC_INSERT;
  logic [IdW-1:0]          entry_id     = '0;
  logic signed [PrioW-1:0] priority_req = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic [1:0]              status;
  logic                    head_valid;
  logic [IdW-1:0]          head_id;
  logic signed [PrioW-1:0] head_priority;
  logic [CountOutW-1:0]    entry_count;

  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_off_left = 0;
  logic        hold_off_req  = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_priority_queue dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (func_sel),
    .entry_id_i      (entry_id),
    .priority_req_i  (priority_req),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .head_valid_o    (head_valid),
    .head_id_o       (head_id),
    .head_priority_o (head_priority),
    .entry_count_o   (entry_count)
  );

  spq_result_checker u_result_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .func_i          (func_sel),
    .entry_id_i      (entry_id),
    .priority_req_i  (priority_req),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .status_i        (status),
    .head_valid_i    (head_valid),
    .head_id_i       (head_id),
    .head_priority_i (head_priority),
    .entry_count_i   (entry_count),
    .errors_o        (mismatch_count),
    .pending_o       (results_owed)
  );

  // Offer one request, idling first at the current rate, and hold it until the transfer.
  task automatic send_request(func_e op, logic [IdW-1:0] id,
                              logic signed [PrioW-1:0] prio);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    func_sel     <= op;
    entry_id     <= id;
    priority_req <= prio;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Result back-pressure: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_left = HoldOffCycles;
        hold_off_req  = 1'b0;
      end
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [IdW-1:0]          id_base;
    logic [IdW-1:0]          id;
    logic signed [PrioW-1:0] prio;
    int unsigned             insert_pct;
    int unsigned             pick;
    func_e                   op;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty queue, extreme ids and priorities, ties, duplicate, full and absent cases.
    send_request(FUNC_REMOVE, 8'd5, 32'sd0);
    send_request(FUNC_INSERT, 8'd0, PrioMax);
    send_request(FUNC_INSERT, 8'd255, PrioMin);
    send_request(FUNC_INSERT, 8'd0, 32'sd9);
    send_request(FUNC_INSERT, 8'd1, PrioMax);
    send_request(FUNC_REMOVE, 8'd0, -32'sd1);
    for (int i = 0; i < 14; i++) begin
      send_request(FUNC_INSERT, IdW'(16 + i), FillPrio[i]);
    end
    send_request(FUNC_INSERT, 8'd200, 32'sd4);
    send_request(FUNC_INSERT, 8'd1, 32'sd4);
    send_request(FUNC_REMOVE, 8'd77, 32'sd0);
    send_request(FUNC_REMOVE, 8'd1, 32'sd0);
    send_request(FUNC_REMOVE, 8'd255, 32'sd0);

    id_base    = '0;
    insert_pct = 50;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) begin
        case ((n / 100) % 4)
          0: begin
            tx_idle_pct  = 0;
            rx_stall_pct = 0;
          end
          1: begin
            tx_idle_pct  = 58;
            rx_stall_pct = 0;
          end
          2: begin
            tx_idle_pct  = 0;
            rx_stall_pct = 58;
          end
          default: begin
            tx_idle_pct  = 23;
            rx_stall_pct = 23;
          end
        endcase
        id_base    = IdW'($urandom_range(255));
        insert_pct = $urandom_range(85, 30);
      end
      // fill the output path while requests keep coming
      if (n == 450) hold_off_req = 1'b1;

      op = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
      // a small pool of handles keeps hits, duplicates and a full table frequent
      if ($urandom_range(99) < 5) id = IdW'($urandom_range(255));
      else id = id_base ^ IdW'($urandom_range(23));
      pick = $urandom_range(9);
      if (pick < 5) prio = $signed(PrioW'($urandom_range(8))) - 32'sd4;
      else if (pick < 8) prio = $urandom();
      else if (pick == 8) prio = PrioMax;
      else prio = PrioMin;
      send_request(op, id, prio);
    end
    in_valid     <= 1'b0;
    rx_stall_pct = 0;

    while (results_owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
